/* hw/rtl/apx_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ARP proxy package
// Shared constants, table geometry, codes, item types, and the command and
// status structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package apx_pkg;

  // Table depth, shared by the MAC table and the IP-to-MAC map.
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned TBL_AW        = $clog2(TABLE_ENTRIES);

  localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
  localparam logic [15:0] OPCODE_REQUEST = 16'h0001;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_REPLY = 2'd1,
    ACT_FLOOD = 2'd2
  } apx_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_FINISH
  } apx_state_e;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [47:0] sender_mac;
    logic [15:0] ingress_port;
  } apx_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] reply_src_ip;
    logic [47:0] reply_src_mac;
    logic [31:0] reply_dst_ip;
    logic [47:0] reply_dst_mac;
    logic [15:0] out_port;
    logic        learn_dropped;
  } apx_res_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // Capture the incoming word and clear the search results.
    logic issue;     // Read the table entry at the scan address, then advance.
    logic commit;    // Write the learned entry, if any.
    logic load_out;  // Move the finished result into the output register.
  } apx_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic arp;        // Captured word is an ARP packet.
    logic scan_last;  // Scan address points at the last table entry.
  } apx_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/apx_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ARP proxy channel interfaces
// Valid/ready channels for the packet header words and the result words.
// ----------------------------------------------------------------------------
interface apx_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] ether_type;
  logic [15:0] arp_opcode;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  logic [47:0] sender_mac;
  logic [15:0] ingress_port;

  modport source (
    output valid, ether_type, arp_opcode, sender_ip, target_ip, sender_mac, ingress_port,
    input  ready
  );
  modport sink (
    input  valid, ether_type, arp_opcode, sender_ip, target_ip, sender_mac, ingress_port,
    output ready
  );
endinterface

interface apx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] reply_src_ip;
  logic [47:0] reply_src_mac;
  logic [31:0] reply_dst_ip;
  logic [47:0] reply_dst_mac;
  logic [15:0] out_port;
  logic        learn_dropped;

  modport source (
    output valid, action, reply_src_ip, reply_src_mac, reply_dst_ip, reply_dst_mac,
           out_port, learn_dropped,
    input  ready
  );
  modport sink (
    input  valid, action, reply_src_ip, reply_src_mac, reply_dst_ip, reply_dst_mac,
           out_port, learn_dropped,
    output ready
  );
endinterface
`default_nettype wire

/* hw/rtl/apx_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ARP proxy controller
// Sequences capture, table scan, learning write and result hand-off.
// ----------------------------------------------------------------------------
module apx_ctrl
  import apx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output apx_cmd_t cmd_o,
  input  apx_sts_t sts_i
);

  apx_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  apx_cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.start = 1'b1;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts_i.arp) begin
          state_d = ST_COMMIT;
        end else begin
          cmd.issue = 1'b1;
          if (sts_i.scan_last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  // An accepted word always starts a scan on the next cycle.
  a_start_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SCAN))
    else $error("accepted word did not start a scan");

  // A new result only appears after the finish step.
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised outside the finish step");

endmodule
`default_nettype wire

/* hw/rtl/apx_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ARP proxy datapath
// Holds the MAC and IP tables, scans them one entry per cycle, writes learned
// entries and forms the result word.
// ----------------------------------------------------------------------------
module apx_dp
  import apx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  apx_cmd_t  cmd_i,
  output apx_sts_t  sts_o,
  input  apx_item_t item_i,
  output apx_res_t  res_o
);

  // Table storage: tags, keys and values have no reset; valid bits do.
  logic [47:0] tag_mem [TABLE_ENTRIES];
  logic [31:0] key_mem [TABLE_ENTRIES];
  logic [47:0] val_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] mac_vld_q;
  logic [TABLE_ENTRIES-1:0] map_vld_q;

  apx_item_t   item_q;
  apx_res_t    res_q;
  logic [TBL_AW-1:0] addr_q;
  logic [TBL_AW-1:0] cmp_idx_q;
  logic        cmp_en_q;
  logic [47:0] tag_rd_q;
  logic [31:0] key_rd_q;
  logic [47:0] val_rd_q;

  // Search results gathered during the scan.
  logic              mac_hit_q;
  logic              ip_found_q;
  logic [TBL_AW-1:0] ip_slot_q;
  logic              mfree_found_q;
  logic [TBL_AW-1:0] mfree_slot_q;
  logic              ifree_found_q;
  logic [TBL_AW-1:0] ifree_slot_q;
  logic              tgt_hit_q;
  logic [47:0]       tgt_val_q;

  logic              cmp_mv, cmp_iv;
  logic              is_arp, is_req, learn, room, do_write, dropped;
  logic              self_hit, reply;
  logic [TBL_AW-1:0] islot;
  apx_res_t          res;

  assign cmp_mv = mac_vld_q[cmp_idx_q];
  assign cmp_iv = map_vld_q[cmp_idx_q];

  // Control flags and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_vld_q     <= '0;
      map_vld_q     <= '0;
      cmp_en_q      <= 1'b0;
      mac_hit_q     <= 1'b0;
      ip_found_q    <= 1'b0;
      mfree_found_q <= 1'b0;
      ifree_found_q <= 1'b0;
      tgt_hit_q     <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.issue;
      if (cmd_i.start) begin
        mac_hit_q     <= 1'b0;
        ip_found_q    <= 1'b0;
        mfree_found_q <= 1'b0;
        ifree_found_q <= 1'b0;
        tgt_hit_q     <= 1'b0;
      end else if (cmp_en_q) begin
        if (cmp_mv && (tag_rd_q == item_q.sender_mac)) begin
          mac_hit_q <= 1'b1;
        end
        if (!cmp_mv) begin
          mfree_found_q <= 1'b1;
        end
        if (cmp_iv && (key_rd_q == item_q.sender_ip)) begin
          ip_found_q <= 1'b1;
        end
        if (!cmp_iv) begin
          ifree_found_q <= 1'b1;
        end
        if (cmp_iv && (key_rd_q == item_q.target_ip)) begin
          tgt_hit_q <= 1'b1;
        end
      end
      if (cmd_i.commit && do_write) begin
        mac_vld_q[mfree_slot_q] <= 1'b1;
        map_vld_q[islot]        <= 1'b1;
      end
    end
  end

  // Payload, scan address, slot numbers and table memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q <= item_i;
      addr_q <= '0;
    end
    if (cmd_i.issue) begin
      tag_rd_q  <= tag_mem[addr_q];
      key_rd_q  <= key_mem[addr_q];
      val_rd_q  <= val_mem[addr_q];
      cmp_idx_q <= addr_q;
      addr_q    <= addr_q + TBL_AW'(1);
    end
    if (cmp_en_q) begin
      if (cmp_iv && (key_rd_q == item_q.sender_ip)) begin
        ip_slot_q <= cmp_idx_q;
      end
      if (!cmp_mv && !mfree_found_q) begin
        mfree_slot_q <= cmp_idx_q;
      end
      if (!cmp_iv && !ifree_found_q) begin
        ifree_slot_q <= cmp_idx_q;
      end
      if (cmp_iv && (key_rd_q == item_q.target_ip)) begin
        tgt_val_q <= val_rd_q;
      end
    end
    if (cmd_i.commit && do_write) begin
      tag_mem[mfree_slot_q] <= item_q.sender_mac;
      key_mem[islot]        <= item_q.sender_ip;
      val_mem[islot]        <= item_q.sender_mac;
    end
    if (cmd_i.load_out) begin
      res_q <= res;
    end
  end

  // Learning is all or nothing; the scan results stay put after the commit,
  // so the result can still be formed from them in the finish step.
  always_comb begin
    is_arp   = (item_q.ether_type == ETH_TYPE_ARP);
    is_req   = (item_q.arp_opcode == OPCODE_REQUEST);
    learn    = is_arp && !mac_hit_q;
    room     = mfree_found_q && (ip_found_q || ifree_found_q);
    do_write = learn && room;
    dropped  = learn && !room;
    islot    = ip_found_q ? ip_slot_q : ifree_slot_q;
    // A request for the address just learned hits the new mapping.
    self_hit = do_write && (item_q.target_ip == item_q.sender_ip);
    reply    = is_arp && is_req && (tgt_hit_q || self_hit);

    res               = '0;
    res.learn_dropped = dropped;
    if (reply) begin
      res.action        = ACT_REPLY;
      res.reply_src_ip  = item_q.target_ip;
      res.reply_src_mac = self_hit ? item_q.sender_mac : tgt_val_q;
      res.reply_dst_ip  = item_q.sender_ip;
      res.reply_dst_mac = item_q.sender_mac;
      res.out_port      = item_q.ingress_port;
    end else if (is_arp && is_req) begin
      res.action = ACT_FLOOD;
    end else begin
      res.action = ACT_NONE;
    end
  end

  assign sts_o.arp       = is_arp;
  assign sts_o.scan_last = (addr_q == TBL_AW'(TABLE_ENTRIES - 1));
  assign res_o           = res_q;

  // Every learned IP comes with a learned MAC, so the map never outgrows
  // the MAC table.
  a_map_le_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(map_vld_q) <= $countones(mac_vld_q))
    else $error("IP map holds more entries than the MAC table");

  // A learning write adds exactly one known MAC.
  a_learn_adds_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && do_write) |=>
      ($countones(mac_vld_q) == $past($countones(mac_vld_q)) + 1))
    else $error("learning write did not add one MAC entry");

endmodule
`default_nettype wire

/* hw/rtl/arp_proxy_learn_and_answer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ARP proxy responder with learning
// Learns sender MAC and IP bindings from ARP packets and answers requests
// for known addresses on behalf of the hosts.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one packet header word per handshake; out_o returns exactly
//   one result word for each, in order. Both are valid/ready channels and a
//   word moves at a rising edge with valid and ready high.
//   Non-ARP words skip the scan and go straight to the learning-write step,
//   which writes nothing for them, and then to the finish step. An ARP word
//   scans both tables, one entry per cycle through a single read port on
//   each table memory, then compares the last entry, makes any learning
//   write and loads the output register. The result is valid the cycle
//   after that load.
//   in_i.ready is high only while the block waits for a word. A result that
//   out_o has not taken yet sits in the output register, and the next word is
//   still accepted and processed; it then waits in its finish step until the
//   output register is free, so nothing is lost or repeated.
//   Reset clears all valid bits of both tables at once, so the block is ready
//   in the first cycle after reset; no clearing pass runs.
// ----------------------------------------------------------------------------
module arp_proxy_learn_and_answer
  import apx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  apx_in_if.sink    in_i,
  apx_out_if.source out_o
);

  apx_cmd_t  cmd;
  apx_sts_t  sts;
  apx_item_t item;
  apx_res_t  res;

  // Header word from the input channel.
  assign item.ether_type   = in_i.ether_type;
  assign item.arp_opcode   = in_i.arp_opcode;
  assign item.sender_ip    = in_i.sender_ip;
  assign item.target_ip    = in_i.target_ip;
  assign item.sender_mac   = in_i.sender_mac;
  assign item.ingress_port = in_i.ingress_port;

  // The controller owns the handshakes and the step sequence.
  apx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the tables and the output register.
  apx_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .item_i (item),
    .res_o  (res)
  );

  assign out_o.action        = res.action;
  assign out_o.reply_src_ip  = res.reply_src_ip;
  assign out_o.reply_src_mac = res.reply_src_mac;
  assign out_o.reply_dst_ip  = res.reply_dst_ip;
  assign out_o.reply_dst_mac = res.reply_dst_mac;
  assign out_o.out_port      = res.out_port;
  assign out_o.learn_dropped = res.learn_dropped;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP proxy responder testbench
// Drives packet header words into the block and checks every result word
// against a behavioral model of the learning tables that the testbench keeps.
// A short directed run is followed by randomized traffic, mostly ARP, that
// fills the tables, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import apx_pkg::*;

  // An ARP reply opcode. It must never trigger an answer.
  localparam logic [15:0] OPCODE_REPLY = 16'h0002;

  // The run is cut off here if the block hangs. Each ARP word costs a full
  // table scan, plus idle cycles on both channels.
  localparam int unsigned CYCLE_LIMIT = 500000;

  // No random idling on either channel inside this window of cycles.
  localparam int unsigned QUIET_LO = 9000;
  localparam int unsigned QUIET_HI = 21000;

  // Cycles to watch for stray result words after the last expected one.
  localparam int unsigned TAIL_CYCLES = TABLE_ENTRIES + 16;

  localparam int unsigned MAC_POOL = 96;
  localparam int unsigned IP_POOL  = 48;

  logic clk_i;
  logic rst_ni;

  apx_in_if  in_bus ();
  apx_out_if out_bus ();

  arp_proxy_learn_and_answer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Header words waiting to be driven, and results still owed by the block.
  apx_item_t hdr_q[$];
  apx_res_t  answer_q[$];

  apx_item_t next_hdr;
  logic      in_took;
  int unsigned cyc;
  int unsigned err_cnt;

  // The testbench's own copy of the two tables.
  logic [47:0] mac_tag [TABLE_ENTRIES];
  logic        mac_vld [TABLE_ENTRIES];
  logic [31:0] ip_key  [TABLE_ENTRIES];
  logic [47:0] ip_mac  [TABLE_ENTRIES];
  logic        ip_vld  [TABLE_ENTRIES];

  logic [47:0] mac_pool [MAC_POOL];
  logic [31:0] ip_pool  [IP_POOL];

  // Clock and reset. Reset is released on a falling edge so that the first
  // word can be driven cleanly.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.ether_type   = '0;
    in_bus.arp_opcode   = '0;
    in_bus.sender_ip    = '0;
    in_bus.target_ip    = '0;
    in_bus.sender_mac   = '0;
    in_bus.ingress_port = '0;
    out_bus.ready       = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic apx_item_t mk_hdr(logic [15:0] et, logic [15:0] op, logic [31:0] sip,
                                       logic [31:0] tip, logic [47:0] mac, logic [15:0] port);
    apx_item_t h;
    h.ether_type   = et;
    h.arp_opcode   = op;
    h.sender_ip    = sip;
    h.target_ip    = tip;
    h.sender_mac   = mac;
    h.ingress_port = port;
    return h;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Random idling, switched off inside the quiet window.
  function automatic bit idle_now();
    if (cyc >= QUIET_LO && cyc < QUIET_HI) return 1'b0;
    return $urandom_range(0, 99) < 13;
  endfunction

  function automatic int find_ip(logic [31:0] ip);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (ip_vld[i] && ip_key[i] == ip) return i;
    return -1;
  endfunction

  // Works out the result word for one header word and updates the tables.
  // Learning is all or nothing and always comes before the lookup, so a
  // request can be answered from the entry that it has just created.
  function automatic apx_res_t answer_arp(apx_item_t h);
    apx_res_t r;
    bit       known;
    int       mslot;
    int       islot;
    int       hit;
    r     = '0;
    known = 1'b0;
    mslot = -1;
    if (h.ether_type == ETH_TYPE_ARP) begin
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (mac_vld[i] && mac_tag[i] == h.sender_mac) known = 1'b1;
      if (!known) begin
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
          if (!mac_vld[i]) mslot = i;
        // An IP that is already mapped is overwritten in place.
        islot = find_ip(h.sender_ip);
        if (islot < 0)
          for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
            if (!ip_vld[i]) islot = i;
        if (mslot < 0 || islot < 0) begin
          r.learn_dropped = 1'b1;
        end else begin
          mac_tag[mslot] = h.sender_mac;
          mac_vld[mslot] = 1'b1;
          ip_key[islot]  = h.sender_ip;
          ip_mac[islot]  = h.sender_mac;
          ip_vld[islot]  = 1'b1;
        end
      end
      if (h.arp_opcode == OPCODE_REQUEST) begin
        hit = find_ip(h.target_ip);
        if (hit >= 0) begin
          r.action        = ACT_REPLY;
          r.reply_src_ip  = h.target_ip;
          r.reply_src_mac = ip_mac[hit];
          r.reply_dst_ip  = h.sender_ip;
          r.reply_dst_mac = h.sender_mac;
          r.out_port      = h.ingress_port;
        end else begin
          r.action = ACT_FLOOD;
        end
      end
    end
    return r;
  endfunction

  task automatic cmp_field(string what, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      err_cnt++;
    end
  endtask

  // Stimulus. The directed words walk through learning, overwriting, known
  // senders, self lookups and odd opcodes; the random part then fills the
  // tables so that most later learning attempts are dropped.
  initial begin
    logic [31:0] ip_a, ip_b, ip_c, ip_d;
    logic [47:0] m1, m2, m3, m4;
    logic [15:0] et;
    logic [15:0] op;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [47:0] mac;
    int unsigned arp_n;
    int unsigned mac_hi;
    int unsigned pick;

    ip_a = 32'hFFFF_FFFF;
    ip_b = 32'h0A00_0001;
    ip_c = 32'h0A00_0002;
    ip_d = 32'hC0A8_0001;
    m1   = 48'hFFFF_FFFF_FFFF;
    m2   = 48'h0000_0000_0001;
    m3   = 48'h0200_0000_0003;
    m4   = 48'h0200_0000_0004;

    // Non-ARP words at the extremes, and the ARP code with its bytes swapped.
    hdr_q.push_back(mk_hdr(16'h0000, 16'h0000, '0, '0, '0, 16'h0000));
    hdr_q.push_back(mk_hdr(16'hFFFF, 16'hFFFF, '1, '1, '1, 16'hFFFF));
    hdr_q.push_back(mk_hdr(16'h0608, OPCODE_REQUEST, ip_b, ip_a, m2, 16'h0001));
    // First request floods, then a second host gets an answer for the first.
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, OPCODE_REQUEST, ip_a, ip_b, m1, 16'hFFFF));
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, OPCODE_REQUEST, ip_b, ip_a, m2, 16'h0001));
    // An ARP reply from a new MAC remaps an existing IP and gives no action.
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, OPCODE_REPLY, ip_a, ip_b, m3, 16'h0002));
    // Known MACs with new IPs learn nothing; only the first is answered.
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, OPCODE_REQUEST, ip_c, ip_a, m2, 16'h0003));
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, OPCODE_REQUEST, ip_d, ip_c, m3, 16'h0004));
    // A request for its own address is answered from the entry just learned.
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, OPCODE_REQUEST, ip_d, ip_d, m4, 16'h0005));
    // Other opcodes only learn.
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, 16'h0000, 32'h0102_0304, ip_a,
                           48'h0A0B_0C0D_0E0F, 16'h0006));
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, 16'hFFFF, 32'h0506_0708, ip_a,
                           48'h1A1B_1C1D_1E1F, 16'h0007));
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, 16'h0100, 32'h090A_0B0C, ip_a,
                           48'h2A2B_2C2D_2E2F, 16'h0008));
    // All-zero addresses are ordinary values.
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, OPCODE_REQUEST, '0, '0, '0, 16'h0000));
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, OPCODE_REQUEST, ip_b, '0, m2, 16'h8000));
    // A new MAC taking over an IP is answered with the new binding.
    hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, OPCODE_REQUEST, ip_b, ip_b,
                           48'h8000_0000_0000, 16'h7FFF));

    for (int i = 0; i < MAC_POOL; i++) mac_pool[i] = rand_mac();
    for (int i = 0; i < IP_POOL; i++) ip_pool[i] = $urandom();

    // Random traffic, mostly ARP. The set of sender MACs in use grows slowly
    // so that the tables fill part way through and stay full for the rest.
    arp_n = 0;
    while (hdr_q.size() < 450) begin
      if ($urandom_range(0, 99) < 8) begin
        et = 16'($urandom());
        if (et == ETH_TYPE_ARP) et[0] = ~et[0];
        hdr_q.push_back(mk_hdr(et, 16'($urandom()), $urandom(), $urandom(), rand_mac(),
                               16'($urandom())));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 78)      op = OPCODE_REQUEST;
        else if (pick < 90) op = OPCODE_REPLY;
        else                op = 16'($urandom());
        mac_hi = (10 + arp_n / 5 < MAC_POOL) ? 10 + arp_n / 5 : MAC_POOL - 1;
        mac = ($urandom_range(0, 99) < 6) ? rand_mac() : mac_pool[$urandom_range(0, mac_hi)];
        sip = ($urandom_range(0, 99) < 15) ? $urandom() : ip_pool[$urandom_range(0, IP_POOL - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 60)      tip = ip_pool[$urandom_range(0, IP_POOL - 1)];
        else if (pick < 70) tip = sip;
        else                tip = $urandom();
        hdr_q.push_back(mk_hdr(ETH_TYPE_ARP, op, sip, tip, mac, 16'($urandom())));
        arp_n++;
      end
    end

    // Wait for every word to be taken, every result to come back, and then
    // a little longer to catch any stray result word.
    @(posedge rst_ni);
    while (hdr_q.size() != 0 || in_bus.valid) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, answer_q.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    cyc     = 0;
    err_cnt = 0;
    in_took = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      mac_vld[i] = 1'b0;
      ip_vld[i]  = 1'b0;
    end
  end

  // Header word driver. A word stays on the bus until it is taken; a fresh
  // word may be held back by a random idle cycle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_took) begin
      if (hdr_q.size() != 0 && !idle_now()) begin
        next_hdr = hdr_q.pop_front();
        in_bus.ether_type   <= next_hdr.ether_type;
        in_bus.arp_opcode   <= next_hdr.arp_opcode;
        in_bus.sender_ip    <= next_hdr.sender_ip;
        in_bus.target_ip    <= next_hdr.target_ip;
        in_bus.sender_mac   <= next_hdr.sender_mac;
        in_bus.ingress_port <= next_hdr.ingress_port;
        in_bus.valid        <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls at random.
  always @(negedge clk_i) begin
    out_bus.ready <= rst_ni && !idle_now();
  end

  // Input monitor: each accepted header word is run through the model and
  // its expected result word is queued.
  always @(posedge clk_i) begin
    in_took <= rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni && in_bus.valid && in_bus.ready)
      answer_q.push_back(answer_arp(mk_hdr(in_bus.ether_type, in_bus.arp_opcode,
                                           in_bus.sender_ip, in_bus.target_ip,
                                           in_bus.sender_mac, in_bus.ingress_port)));
  end

  // Output monitor: each result word is checked against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    apx_res_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got action %0d",
                 $time, out_bus.action);
        err_cnt++;
      end else begin
        want = answer_q.pop_front();
        cmp_field("action",        48'(want.action),        48'(out_bus.action));
        cmp_field("reply_src_ip",  48'(want.reply_src_ip),  48'(out_bus.reply_src_ip));
        cmp_field("reply_src_mac", want.reply_src_mac,      out_bus.reply_src_mac);
        cmp_field("reply_dst_ip",  48'(want.reply_dst_ip),  48'(out_bus.reply_dst_ip));
        cmp_field("reply_dst_mac", want.reply_dst_mac,      out_bus.reply_dst_mac);
        cmp_field("out_port",      48'(want.out_port),      48'(out_bus.out_port));
        cmp_field("learn_dropped", 48'(want.learn_dropped), 48'(out_bus.learn_dropped));
      end
    end
  end

endmodule
